[src/ftpcl_pkg.sv]
// ----------------------------------------------------------------------------
// ftpcl_pkg: shared definitions for the FTP command line parser
// Command codes, keyword table, argument counter sizing and the result type.
// ----------------------------------------------------------------------------
package ftpcl_pkg;

	// Largest argument length that is counted before the overflow flag is set.
	localparam int MAX_PARAM = 255;
	localparam int ARG_W     = $clog2(MAX_PARAM + 1);

	localparam int KEY_COUNT = 10;

	// Control characters that take part in parsing.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef enum logic [3:0] {
		CMD_INVALID = 4'd0,
		CMD_QUIT    = 4'd1,
		CMD_USER    = 4'd2,
		CMD_CWD     = 4'd3,
		CMD_CDUP    = 4'd4,
		CMD_TYPE    = 4'd5,
		CMD_MODE    = 4'd6,
		CMD_STRU    = 4'd7,
		CMD_RETR    = 4'd8,
		CMD_PASV    = 4'd9,
		CMD_NLST    = 4'd10
	} cmd_t;

	// Keyword text, first character in the top byte; short words pad with zero.
	localparam logic [31:0] KEY_TEXT [KEY_COUNT] = '{
		"QUIT", "USER", {"CWD", 8'h00}, "CDUP", "TYPE",
		"MODE", "STRU", "RETR", "PASV", "NLST"
	};
	localparam logic [2:0] KEY_LEN [KEY_COUNT] = '{
		3'd4, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
	};

	typedef logic [7:0] word_t [4];

	typedef struct packed {
		logic       kind;
		logic [7:0] arg_byte;
		logic [3:0] command;
		logic [7:0] arg_length;
		logic       arg_overflow;
	} res_t;

	// Match the collected command word against the keyword table.
	// Each keyword is compared independently; the lowest table index that matches wins.
	function automatic cmd_t match_word(input word_t chars, input logic [2:0] len);
		cmd_t code;
		logic same;
		code = CMD_INVALID;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			same = (len == KEY_LEN[k]);
			for (int j = 0; j < 4; j++) begin
				if ((3'(j) < KEY_LEN[k]) && (chars[j] != KEY_TEXT[k][31 - 8 * j -: 8])) begin
					same = 1'b0;
				end
			end
			if (same) begin
				code = cmd_t'(4'(k + 1));
			end
		end
		return code;
	endfunction

endpackage

[src/ftp_command_line_parser_core.sv]
// ----------------------------------------------------------------------------
// ftp_command_line_parser_core: FTP control line parser
// Collects and upper-cases the command word, echoes argument bytes and, at
// the terminating zero byte, reports the matched command and argument length.
// ----------------------------------------------------------------------------
// Path: an accepted input beat passes the input register, then the result
// register, to its result beat; bytes that cause no result leave none.
// Throughput: one byte per cycle while the output is not stalled; while a
// result waits on a stalled output the input side takes at most one more beat
// and then holds tready low.
// Reset: arst_n clears all parser state and both valid flags at once.
module ftp_command_line_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [7:0] arg_byte, [11:8] command,
	                                   // [19:12] arg_length, [20] arg_overflow,
	                                   // [23:21] zero
	output logic        m_axis_tuser   // [0] kind
);
	import ftpcl_pkg::*;

	localparam logic [ARG_W-1:0] ARG_MAX = ARG_W'(MAX_PARAM);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register.
	logic out_valid_q;
	res_t out_res_q;

	// Parser state.
	logic             in_argument_q, space_armed_q, line_ended_q, overflow_seen_q;
	word_t            word_chars_q;
	logic [2:0]       word_length_q;
	logic [ARG_W-1:0] arg_count_q, arg_trimmed_q;

	// Next state and the result of the byte in the input register.
	logic             in_argument_d, space_armed_d, line_ended_d, overflow_seen_d;
	word_t            word_chars_d;
	logic [2:0]       word_length_d;
	logic [ARG_W-1:0] arg_count_d, arg_trimmed_d;
	logic             res_valid;
	res_t             res;
	logic [7:0]       upper_c;
	logic [ARG_W+7:0] trimmed_ext;

	logic advance;

	// The result register is free, or is being emptied this cycle.
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	assign trimmed_ext = {8'd0, arg_trimmed_q};

	// Per-byte parsing step.
	always_comb begin
		in_argument_d   = in_argument_q;
		space_armed_d   = space_armed_q;
		line_ended_d    = line_ended_q;
		overflow_seen_d = overflow_seen_q;
		word_chars_d    = word_chars_q;
		word_length_d   = word_length_q;
		arg_count_d     = arg_count_q;
		arg_trimmed_d   = arg_trimmed_q;
		res_valid       = 1'b0;
		res             = '0;
		upper_c         = byte_s1;
		if ((byte_s1 >= CHAR_LC_A) && (byte_s1 <= CHAR_LC_Z)) begin
			upper_c = byte_s1 - CASE_DIFF;
		end

		if (byte_s1 == CHAR_NUL) begin
			// End of buffer: report and return to the reset state.
			res_valid          = 1'b1;
			res.kind           = 1'b1;
			res.command        = match_word(word_chars_q, word_length_q);
			res.arg_length     = trimmed_ext[7:0];
			res.arg_overflow   = overflow_seen_q;
			in_argument_d      = 1'b0;
			space_armed_d      = 1'b0;
			line_ended_d       = 1'b0;
			overflow_seen_d    = 1'b0;
			word_chars_d       = '{default: 8'd0};
			word_length_d      = 3'd0;
			arg_count_d        = '0;
			arg_trimmed_d      = '0;
		end else if (line_ended_q) begin
			// Bytes after the line end are dropped.
		end else if ((byte_s1 == CHAR_CR) || (byte_s1 == CHAR_LF)) begin
			line_ended_d = 1'b1;
		end else if (!in_argument_q && (byte_s1 == CHAR_SPACE)) begin
			space_armed_d = 1'b1;
		end else if (!in_argument_q && !space_armed_q) begin
			// Command word character.
			if (word_length_q < 3'd4) begin
				word_chars_d[word_length_q[1:0]] = upper_c;
			end
			if (word_length_q < 3'd5) begin
				word_length_d = word_length_q + 3'd1;
			end
		end else begin
			// Argument byte: count, track trailing spaces and echo it.
			in_argument_d = 1'b1;
			if (arg_count_q < ARG_MAX) begin
				arg_count_d = arg_count_q + 1'b1;
			end else begin
				overflow_seen_d = 1'b1;
			end
			if (byte_s1 != CHAR_SPACE) begin
				arg_trimmed_d = arg_count_d;
			end
			res_valid    = 1'b1;
			res.arg_byte = byte_s1;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Parser state, updated as each byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_argument_q   <= 1'b0;
			space_armed_q   <= 1'b0;
			line_ended_q    <= 1'b0;
			overflow_seen_q <= 1'b0;
			word_chars_q    <= '{default: 8'd0};
			word_length_q   <= 3'd0;
			arg_count_q     <= '0;
			arg_trimmed_q   <= '0;
		end else if (valid_s1 && advance) begin
			in_argument_q   <= in_argument_d;
			space_armed_q   <= space_armed_d;
			line_ended_q    <= line_ended_d;
			overflow_seen_q <= overflow_seen_d;
			word_chars_q    <= word_chars_d;
			word_length_q   <= word_length_d;
			arg_count_q     <= arg_count_d;
			arg_trimmed_q   <= arg_trimmed_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_res_q.kind;
	assign m_axis_tdata  = {3'd0, out_res_q.arg_overflow, out_res_q.arg_length,
	                        out_res_q.command, out_res_q.arg_byte};

	// Checks on the parser state.
	a_word_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		word_length_q <= 3'd5)
		else $error("command word length above saturation");

	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		arg_count_q <= ARG_MAX)
		else $error("argument count above limit");

	a_trim_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		arg_trimmed_q <= arg_count_q)
		else $error("trimmed length exceeds argument count");

	a_ovf_at_max: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_seen_q |-> (arg_count_q == ARG_MAX))
		else $error("overflow flagged below the limit");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && (byte_s1 == CHAR_NUL)) |=>
		(out_valid_q && out_res_q.kind && (word_length_q == 3'd0)
		 && (arg_count_q == '0) && !in_argument_q && !line_ended_q))
		else $error("end of buffer did not report and clear state");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for the FTP command line parser core
// Feeds control lines one byte per beat, predicts argument echoes and final
// command results in the bench, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb;
	import ftpcl_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 350;
	localparam int QUIET_TAIL   = 150;
	localparam int MAX_REPORTS  = 30;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;

	// Bench copy of the parser state.
	logic       in_argument;
	logic       space_armed;
	logic       line_ended;
	logic [7:0] word_chars [4];
	int         word_len;
	int         arg_count;
	int         trimmed_len;
	logic       overflow_seen;

	res_t        pending_results [$];
	int          errors     = 0;
	int unsigned cycles     = 0;
	int          bytes_sent = 0;
	int          idle_pct   = 0;
	int          stall_left = 0;

	string keywords [KEY_COUNT] = '{
		"QUIT", "USER", "CWD", "CDUP", "TYPE", "MODE", "STRU", "RETR", "PASV", "NLST"
	};

	ftp_command_line_parser_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Clock with a period of 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (errors < MAX_REPORTS) begin
			$display("ERROR cycle %0d: %s", cycles, msg);
		end
		errors++;
	endtask

	function automatic void clear_parser();
		in_argument   = 1'b0;
		space_armed   = 1'b0;
		line_ended    = 1'b0;
		word_chars    = '{default: 8'h00};
		word_len      = 0;
		arg_count     = 0;
		trimmed_len   = 0;
		overflow_seen = 1'b0;
	endfunction

	// Command code for the collected word; only exact keyword lengths match.
	function automatic cmd_t lookup_command();
		logic [31:0] w;
		w = {word_chars[0], word_chars[1], word_chars[2], word_chars[3]};
		if (word_len == 3) begin
			return (w[31:8] == "CWD") ? CMD_CWD : CMD_INVALID;
		end
		if (word_len != 4) begin
			return CMD_INVALID;
		end
		case (w)
			"QUIT": return CMD_QUIT;
			"USER": return CMD_USER;
			"CDUP": return CMD_CDUP;
			"TYPE": return CMD_TYPE;
			"MODE": return CMD_MODE;
			"STRU": return CMD_STRU;
			"RETR": return CMD_RETR;
			"PASV": return CMD_PASV;
			"NLST": return CMD_NLST;
			default: return CMD_INVALID;
		endcase
	endfunction

	// Advance the bench parser by one accepted byte and queue what it yields.
	function automatic void parse_byte(input logic [7:0] b);
		res_t       r;
		logic [7:0] c;
		r = '0;
		if (b == CHAR_NUL) begin
			r.kind         = 1'b1;
			r.command      = lookup_command();
			r.arg_length   = trimmed_len[7:0];
			r.arg_overflow = overflow_seen;
			pending_results.push_back(r);
			clear_parser();
			return;
		end
		if (line_ended) begin
			return;
		end
		if (b == CHAR_CR || b == CHAR_LF) begin
			line_ended = 1'b1;
			return;
		end
		if (!in_argument) begin
			if (b == CHAR_SPACE) begin
				space_armed = 1'b1;
				return;
			end
			if (!space_armed) begin
				c = b;
				if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
					c = c - CASE_DIFF;
				end
				if (word_len < 4) begin
					word_chars[word_len] = c;
				end
				if (word_len < 5) begin
					word_len++;
				end
				return;
			end
			in_argument = 1'b1;
		end
		if (arg_count < MAX_PARAM) begin
			arg_count++;
		end else begin
			overflow_seen = 1'b1;
		end
		if (b != CHAR_SPACE) begin
			trimmed_len = arg_count;
		end
		r.arg_byte = b;
		pending_results.push_back(r);
	endfunction

	// Result checker: each beat against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected, tdata %h",
					m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch($sformatf("kind %b, expected %b", m_axis_tuser, want.kind));
				if (m_axis_tdata[7:0] !== want.arg_byte)
					report_mismatch($sformatf("arg_byte %h, expected %h",
						m_axis_tdata[7:0], want.arg_byte));
				if (m_axis_tdata[11:8] !== want.command)
					report_mismatch($sformatf("command %0d, expected %0d",
						m_axis_tdata[11:8], want.command));
				if (m_axis_tdata[19:12] !== want.arg_length)
					report_mismatch($sformatf("arg_length %0d, expected %0d",
						m_axis_tdata[19:12], want.arg_length));
				if (m_axis_tdata[20] !== want.arg_overflow)
					report_mismatch($sformatf("arg_overflow %b, expected %b",
						m_axis_tdata[20], want.arg_overflow));
			end
		end
	end

	// Output side: random stall bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left = $urandom_range(0, 8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Send one byte as one beat, with an optional idle burst ahead of it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		parse_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_crlf_end();
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(CHAR_NUL);
	endtask

	// Every keyword, mixed case, with and without an argument.
	task automatic test_keywords();
		string lines [KEY_COUNT] = '{
			"quit", "User anon", "CWD /pub", "cdup", "tYpe I",
			"mode S", "Stru F", "retr file.txt", "pasv", "NLST dir"
		};
		idle_pct = 0;
		foreach (lines[i]) begin
			send_text(lines[i]);
			send_crlf_end();
		end
		wait_drain();
	endtask

	// Empty, short, long and unmatched words, and bytes next to the letter range.
	task automatic test_word_forms();
		idle_pct = 20;
		send_byte(CHAR_NUL);
		send_text("QUITX now");
		send_byte(CHAR_NUL);
		send_text("cw");
		send_byte(CHAR_NUL);
		send_text("{uit");
		send_byte(CHAR_NUL);
		send_text("`wd x");
		send_byte(CHAR_NUL);
		send_text(" lead");
		send_byte(CHAR_NUL);
		send_byte(8'hff);
		send_byte(8'h80);
		send_text("zz ");
		send_byte(8'hff);
		send_byte(CHAR_NUL);
		wait_drain();
	endtask

	// Runs of spaces before, inside and after the argument.
	task automatic test_spacing();
		idle_pct = 40;
		send_text("USER    bob   ");
		send_crlf_end();
		send_text("CWD    ");
		send_crlf_end();
		send_text("RETR a b  c ");
		send_byte(CHAR_NUL);
		wait_drain();
	endtask

	// Bytes after a line end are dropped until the end of the buffer.
	task automatic test_line_end();
		idle_pct = 20;
		send_text("QUIT");
		send_byte(CHAR_CR);
		send_text("USER x");
		send_byte(CHAR_NUL);
		send_text("USER ab");
		send_byte(CHAR_LF);
		send_text("zz  cd");
		send_byte(CHAR_NUL);
		send_text("TYPE A");
		send_byte(CHAR_CR);
		send_byte(8'h80);
		send_byte(8'hff);
		send_byte(CHAR_NUL);
		wait_drain();
	endtask

	// Argument lengths at the saturation point, and past it with trailing spaces.
	task automatic test_argument_overflow();
		idle_pct = 10;
		send_text("USER ");
		repeat (MAX_PARAM) send_byte("a");
		send_byte(CHAR_NUL);
		send_text("STRU ");
		repeat (MAX_PARAM - 5) send_byte("c");
		repeat (10) send_byte(CHAR_SPACE);
		send_crlf_end();
		wait_drain();
	endtask

	// One random line: mostly well formed, sometimes noise or a broken ending.
	task automatic random_line();
		int         shape;
		int         n;
		logic [7:0] c;
		string      word;
		shape = $urandom_range(0, 9);
		if (shape == 0) begin
			n = $urandom_range(0, 12);
			repeat (n) send_byte(8'($urandom_range(1, 255)));
			send_byte(CHAR_NUL);
			return;
		end
		// Command word: a keyword in random case or random printable bytes.
		if ($urandom_range(0, 4) != 0) begin
			word = keywords[$urandom_range(0, KEY_COUNT - 1)];
			for (int i = 0; i < word.len(); i++) begin
				c = word[i];
				if ($urandom_range(0, 1) == 1) c = c + CASE_DIFF;
				send_byte(c);
			end
		end else begin
			n = $urandom_range(0, 6);
			repeat (n) send_byte(8'($urandom_range(33, 126)));
		end
		repeat ($urandom_range(0, 3)) send_byte(CHAR_SPACE);
		// Argument, rarely long enough to saturate.
		n = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 16);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: c = CHAR_SPACE;
				1: c = 8'($urandom_range(128, 255));
				default: c = 8'($urandom_range(33, 126));
			endcase
			send_byte(c);
		end
		if (n != 0) repeat ($urandom_range(0, 2)) send_byte(CHAR_SPACE);
		// Line ending, sometimes missing, sometimes with trailing junk.
		case ($urandom_range(0, 4))
			1: begin
				send_byte(CHAR_CR);
				send_byte(CHAR_LF);
			end
			2: send_byte(CHAR_CR);
			3: send_byte(CHAR_LF);
			4: begin
				send_byte(CHAR_CR);
				send_byte(CHAR_LF);
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(1, 255)));
			end
			default: ;
		endcase
		send_byte(CHAR_NUL);
	endtask

	// Random lines with varying idle rates, one drain pause, and a quiet tail.
	task automatic test_random_lines();
		int  start;
		bit  paused;
		int  rates [3] = '{0, 15, 40};
		start  = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (bytes_sent - start >= RANDOM_BYTES - QUIET_TAIL) begin
				idle_pct = 0;
			end else begin
				idle_pct = rates[$urandom_range(0, 2)];
			end
			if (!paused && bytes_sent - start >= RANDOM_BYTES / 2) begin
				wait_drain();
				paused = 1'b1;
			end
			random_line();
		end
	endtask

	// Main sequence.
	initial begin
		clear_parser();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_keywords();
		test_word_forms();
		test_spacing();
		test_line_end();
		test_argument_overflow();
		test_random_lines();
		idle_pct = 0;
		wait_drain();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
src/ftpcl_pkg.sv
src/ftp_command_line_parser_core.sv
dv/tb.sv
